// ----- hdl/pllm_pkg.sv -----
package pllm_pkg;

	localparam int NODES = 128;
	localparam int IDX_W = $clog2(NODES);
	localparam int PTR_W = $clog2(NODES + 1);
	localparam int CNT_W = $clog2(NODES + 1);
	localparam int VAL_W = 32;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [CNT_W-1:0] cnt_t;

	localparam ptr_t NIL = PTR_W'(NODES);

	typedef enum logic [2:0] {
		CMD_INS_HEAD  = 3'd0,
		CMD_INS_TAIL  = 3'd1,
		CMD_INS_AFTER = 3'd2,
		CMD_DELETE    = 3'd3,
		CMD_SEARCH    = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_FULL      = 2'd1,
		STS_NOT_FOUND = 2'd2,
		STS_EMPTY     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ALLOC,
		S_FIND,
		S_TAIL,
		S_DEL,
		S_LINK
	} state_t;

	typedef struct packed {
		logic             rd_en;
		idx_t             rd_addr;
		logic             val_we;
		idx_t             val_addr;
		logic [VAL_W-1:0] val_data;
		logic             nxt_we;
		idx_t             nxt_addr;
		ptr_t             nxt_data;
	} store_req_t;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		ptr_t             next;
	} store_rsp_t;

	function automatic logic is_node(ptr_t p);
		return p < NIL;
	endfunction

	function automatic idx_t to_idx(ptr_t p);
		return p[IDX_W-1:0];
	endfunction

endpackage

// ----- hdl/pllm_store.sv -----
module pllm_store (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pllm_pkg::store_req_t   req,
	output pllm_pkg::store_rsp_t   rsp
);

	logic [pllm_pkg::VAL_W-1:0] value_mem [pllm_pkg::NODES];
	pllm_pkg::ptr_t             next_mem  [pllm_pkg::NODES];
	logic [pllm_pkg::NODES-1:0] vld_q;
	logic                       rd_vld_q;
	pllm_pkg::idx_t             rd_addr_q;
	logic [pllm_pkg::VAL_W-1:0] value_q;
	pllm_pkg::ptr_t             next_q;

	always_ff @(posedge clk) begin
		if (req.val_we) begin
			value_mem[req.val_addr] <= req.val_data;
		end
		if (req.nxt_we) begin
			next_mem[req.nxt_addr] <= req.nxt_data;
		end
		if (req.rd_en) begin
			value_q   <= value_mem[req.rd_addr];
			next_q    <= next_mem[req.rd_addr];
			rd_addr_q <= req.rd_addr;
		end
	end

	// unwritten next entries read as their reset chain value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.nxt_we) begin
				vld_q[req.nxt_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_q <= vld_q[req.rd_addr];
			end
		end
	end

	assign rsp.value = value_q;
	assign rsp.next  = rd_vld_q ? next_q
	                            : pllm_pkg::ptr_t'(rd_addr_q) + pllm_pkg::ptr_t'(1);

endmodule

// ----- hdl/pooled_linked_list_manager_core.sv -----
// Linked list in a pool of 128 nodes with a free list. A command is taken when
// start is high and busy is low; busy then stays high until the result, which
// appears for one cycle with done and cannot be held off by the receiver. A
// full pool, an empty list or an unused command is answered from idle, with
// busy staying low. Insert head reads the free head, then allocates. Search,
// insert after and delete walk the list one node per cycle through the single
// read port of the node store: search and delete at the head end in the walk,
// any other delete unlinks afterwards, and insert after allocates and then
// links, or ends in the walk on a full pool. A walk for an absent key runs to
// the list end. Insert tail allocates, then walks to the end of a non-empty
// list. The next command can be taken in the cycle where done is high.
module pooled_linked_list_manager_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  command,
	input  logic signed [31:0] key,
	input  logic signed [31:0] new_value,
	output logic        done,
	output logic [1:0]  status,
	output logic [7:0]  position,
	output logic [6:0]  node_index,
	output logic [7:0]  live_nodes
);

	pllm_pkg::state_t     state_q, state_d;
	pllm_pkg::store_req_t req;
	pllm_pkg::store_rsp_t rsp;

	pllm_pkg::cmd_t             cmd_q, cmd_d;
	logic [pllm_pkg::VAL_W-1:0] key_q, key_d, val_q, val_d;
	pllm_pkg::ptr_t             cur_q, cur_d, prev_q, prev_d;
	pllm_pkg::ptr_t             new_q, new_d, hit_q, hit_d, hit_next_q, hit_next_d;
	pllm_pkg::cnt_t             steps_q, steps_d, steps_inc;
	pllm_pkg::ptr_t             list_head_q, list_head_d, free_head_q, free_head_d;
	pllm_pkg::cnt_t             count_q, count_d;

	logic                  fin;
	pllm_pkg::status_t     res_status;
	logic [7:0]            res_pos;
	pllm_pkg::idx_t        res_idx;

	logic                  done_q;
	logic [1:0]            status_q;
	logic [7:0]            pos_q, live_q;
	logic [6:0]            idx_q;

	logic hit, head_ok, free_ok, nxt_ok, walk_more, tail_more;

	pllm_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	assign steps_inc = steps_q + pllm_pkg::cnt_t'(1);
	assign hit       = rsp.value == key_q;
	assign head_ok   = pllm_pkg::is_node(list_head_q);
	assign free_ok   = pllm_pkg::is_node(free_head_q);
	assign nxt_ok    = pllm_pkg::is_node(rsp.next);
	assign walk_more = nxt_ok && (steps_inc < pllm_pkg::cnt_t'(pllm_pkg::NODES));
	assign tail_more = nxt_ok && (steps_q < pllm_pkg::cnt_t'(pllm_pkg::NODES));

	always_comb begin
		state_d = state_q;
		case (state_q)
			pllm_pkg::S_IDLE: begin
				if (start) begin
					case (pllm_pkg::cmd_t'(command))
						pllm_pkg::CMD_INS_HEAD,
						pllm_pkg::CMD_INS_TAIL: begin
							if (free_ok) state_d = pllm_pkg::S_ALLOC;
						end
						pllm_pkg::CMD_INS_AFTER,
						pllm_pkg::CMD_DELETE,
						pllm_pkg::CMD_SEARCH: begin
							if (head_ok) state_d = pllm_pkg::S_FIND;
						end
						default: state_d = pllm_pkg::S_IDLE;
					endcase
				end
			end
			pllm_pkg::S_FIND: begin
				if (hit) begin
					case (cmd_q)
						pllm_pkg::CMD_INS_AFTER: begin
							state_d = free_ok ? pllm_pkg::S_ALLOC : pllm_pkg::S_IDLE;
						end
						pllm_pkg::CMD_DELETE: begin
							state_d = pllm_pkg::is_node(prev_q) ? pllm_pkg::S_DEL
							                                     : pllm_pkg::S_IDLE;
						end
						default: state_d = pllm_pkg::S_IDLE;
					endcase
				end else if (!walk_more) begin
					state_d = pllm_pkg::S_IDLE;
				end
			end
			pllm_pkg::S_ALLOC: begin
				case (cmd_q)
					pllm_pkg::CMD_INS_AFTER: state_d = pllm_pkg::S_LINK;
					pllm_pkg::CMD_INS_TAIL: begin
						state_d = head_ok ? pllm_pkg::S_TAIL : pllm_pkg::S_IDLE;
					end
					default: state_d = pllm_pkg::S_IDLE;
				endcase
			end
			pllm_pkg::S_TAIL: begin
				if (!tail_more) state_d = pllm_pkg::S_IDLE;
			end
			pllm_pkg::S_DEL:  state_d = pllm_pkg::S_IDLE;
			pllm_pkg::S_LINK: state_d = pllm_pkg::S_IDLE;
			default:          state_d = pllm_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		req         = '0;
		fin         = 1'b0;
		res_status  = pllm_pkg::STS_OK;
		res_pos     = '0;
		res_idx     = '0;
		cmd_d       = cmd_q;
		key_d       = key_q;
		val_d       = val_q;
		cur_d       = cur_q;
		prev_d      = prev_q;
		steps_d     = steps_q;
		new_d       = new_q;
		hit_d       = hit_q;
		hit_next_d  = hit_next_q;
		list_head_d = list_head_q;
		free_head_d = free_head_q;
		count_d     = count_q;
		case (state_q)
			pllm_pkg::S_IDLE: begin
				if (start) begin
					cmd_d = pllm_pkg::cmd_t'(command);
					key_d = key;
					val_d = new_value;
					case (pllm_pkg::cmd_t'(command))
						pllm_pkg::CMD_INS_HEAD,
						pllm_pkg::CMD_INS_TAIL: begin
							if (free_ok) begin
								req.rd_en   = 1'b1;
								req.rd_addr = pllm_pkg::to_idx(free_head_q);
							end else begin
								fin        = 1'b1;
								res_status = pllm_pkg::STS_FULL;
							end
						end
						pllm_pkg::CMD_INS_AFTER,
						pllm_pkg::CMD_DELETE,
						pllm_pkg::CMD_SEARCH: begin
							if (head_ok) begin
								req.rd_en   = 1'b1;
								req.rd_addr = pllm_pkg::to_idx(list_head_q);
								cur_d       = list_head_q;
								prev_d      = pllm_pkg::NIL;
								steps_d     = '0;
							end else begin
								fin        = 1'b1;
								res_status = (pllm_pkg::cmd_t'(command) == pllm_pkg::CMD_DELETE)
								           ? pllm_pkg::STS_EMPTY : pllm_pkg::STS_NOT_FOUND;
							end
						end
						default: fin = 1'b1;
					endcase
				end
			end
			pllm_pkg::S_FIND: begin
				if (hit) begin
					case (cmd_q)
						pllm_pkg::CMD_INS_AFTER: begin
							hit_d      = cur_q;
							hit_next_d = rsp.next;
							if (free_ok) begin
								req.rd_en   = 1'b1;
								req.rd_addr = pllm_pkg::to_idx(free_head_q);
							end else begin
								fin        = 1'b1;
								res_status = pllm_pkg::STS_FULL;
							end
						end
						pllm_pkg::CMD_DELETE: begin
							req.nxt_we   = 1'b1;
							req.nxt_addr = pllm_pkg::to_idx(cur_q);
							req.nxt_data = free_head_q;
							free_head_d  = cur_q;
							if (count_q != '0) count_d = count_q - pllm_pkg::cnt_t'(1);
							if (pllm_pkg::is_node(prev_q)) begin
								hit_next_d = rsp.next;
							end else begin
								list_head_d = rsp.next;
								fin         = 1'b1;
								res_idx     = pllm_pkg::to_idx(cur_q);
							end
						end
						default: begin
							fin     = 1'b1;
							res_pos = 8'(steps_inc);
							res_idx = pllm_pkg::to_idx(cur_q);
						end
					endcase
				end else if (walk_more) begin
					req.rd_en   = 1'b1;
					req.rd_addr = pllm_pkg::to_idx(rsp.next);
					prev_d      = cur_q;
					cur_d       = rsp.next;
					steps_d     = steps_inc;
				end else begin
					fin        = 1'b1;
					res_status = pllm_pkg::STS_NOT_FOUND;
				end
			end
			pllm_pkg::S_ALLOC: begin
				new_d        = free_head_q;
				free_head_d  = rsp.next;
				count_d      = count_q + pllm_pkg::cnt_t'(1);
				req.val_we   = 1'b1;
				req.val_addr = pllm_pkg::to_idx(free_head_q);
				req.val_data = val_q;
				req.nxt_we   = 1'b1;
				req.nxt_addr = pllm_pkg::to_idx(free_head_q);
				case (cmd_q)
					pllm_pkg::CMD_INS_AFTER: begin
						req.nxt_data = hit_next_q;
					end
					pllm_pkg::CMD_INS_TAIL: begin
						req.nxt_data = pllm_pkg::NIL;
						if (head_ok) begin
							req.rd_en   = 1'b1;
							req.rd_addr = pllm_pkg::to_idx(list_head_q);
							cur_d       = list_head_q;
							steps_d     = '0;
						end else begin
							list_head_d = free_head_q;
							fin         = 1'b1;
							res_idx     = pllm_pkg::to_idx(free_head_q);
						end
					end
					default: begin
						req.nxt_data = list_head_q;
						list_head_d  = free_head_q;
						fin          = 1'b1;
						res_idx      = pllm_pkg::to_idx(free_head_q);
					end
				endcase
			end
			pllm_pkg::S_TAIL: begin
				if (tail_more) begin
					req.rd_en   = 1'b1;
					req.rd_addr = pllm_pkg::to_idx(rsp.next);
					cur_d       = rsp.next;
					steps_d     = steps_inc;
				end else begin
					req.nxt_we   = 1'b1;
					req.nxt_addr = pllm_pkg::to_idx(cur_q);
					req.nxt_data = new_q;
					fin          = 1'b1;
					res_idx      = pllm_pkg::to_idx(new_q);
				end
			end
			pllm_pkg::S_DEL: begin
				req.nxt_we   = 1'b1;
				req.nxt_addr = pllm_pkg::to_idx(prev_q);
				req.nxt_data = hit_next_q;
				fin          = 1'b1;
				res_idx      = pllm_pkg::to_idx(cur_q);
			end
			pllm_pkg::S_LINK: begin
				req.nxt_we   = 1'b1;
				req.nxt_addr = pllm_pkg::to_idx(hit_q);
				req.nxt_data = new_q;
				fin          = 1'b1;
				res_idx      = pllm_pkg::to_idx(new_q);
			end
			default: fin = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pllm_pkg::S_IDLE;
			list_head_q <= pllm_pkg::NIL;
			free_head_q <= '0;
			count_q     <= '0;
			done_q      <= 1'b0;
		end else begin
			state_q     <= state_d;
			list_head_q <= list_head_d;
			free_head_q <= free_head_d;
			count_q     <= count_d;
			done_q      <= fin;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q      <= cmd_d;
		key_q      <= key_d;
		val_q      <= val_d;
		cur_q      <= cur_d;
		prev_q     <= prev_d;
		steps_q    <= steps_d;
		new_q      <= new_d;
		hit_q      <= hit_d;
		hit_next_q <= hit_next_d;
		if (fin) begin
			status_q <= res_status;
			pos_q    <= res_pos;
			idx_q    <= 7'(res_idx);
			live_q   <= 8'(count_d);
		end
	end

	assign busy       = state_q != pllm_pkg::S_IDLE;
	assign done       = done_q;
	assign status     = status_q;
	assign position   = pos_q;
	assign node_index = idx_q;
	assign live_nodes = live_q;

endmodule

// ----- tb/tb_pooled_linked_list_manager_core.sv -----
`timescale 1ns / 100ps

module tb_pooled_linked_list_manager_core;
	import pllm_pkg::*;

	localparam int HALF_PERIOD = 4;
	localparam int RESET_CYCLES = 11;
	localparam int RANDOM_ITEMS = 650;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 150;

	typedef struct {
		logic [2:0]  cmd;
		logic [31:0] key;
		logic [31:0] value;
	} cmd_item_t;

	typedef struct {
		status_t     status;
		logic [7:0]  position;
		idx_t        node_index;
		logic [7:0]  live;
	} list_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [2:0] command = 3'd0;
	logic signed [31:0] key = 32'sd0;
	logic signed [31:0] new_value = 32'sd0;
	logic busy;
	logic done;
	logic [1:0] status;
	logic [7:0] position;
	logic [6:0] node_index;
	logic [7:0] live_nodes;

	cmd_item_t cmd_q[$];
	list_result_t due_q[$];
	logic [31:0] live_vals[$];

	logic [31:0] val_mem[NODES];
	ptr_t next_mem[NODES];
	ptr_t head_p;
	ptr_t free_p;
	int node_cnt;

	int n_accepted = 0;
	int n_results = 0;
	int n_errors = 0;
	int n_full = 0;
	int n_missing = 0;
	int n_empty = 0;
	int stall_cycles = 0;

	pooled_linked_list_manager_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.key(key),
		.new_value(new_value),
		.done(done),
		.status(status),
		.position(position),
		.node_index(node_index),
		.live_nodes(live_nodes)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic ptr_t locate(input logic [31:0] k, output ptr_t prev,
			output logic [7:0] pos);
		ptr_t cur;
		int steps;
		cur = head_p;
		prev = NIL;
		pos = 8'd0;
		steps = 0;
		while (cur < NIL && steps < NODES) begin
			steps++;
			if (val_mem[cur[IDX_W-1:0]] == k) begin
				pos = steps[7:0];
				return cur;
			end
			prev = cur;
			cur = next_mem[cur[IDX_W-1:0]];
		end
		prev = NIL;
		return NIL;
	endfunction

	function automatic ptr_t take_node();
		ptr_t n;
		n = free_p;
		if (n < NIL) begin
			free_p = next_mem[n[IDX_W-1:0]];
			node_cnt++;
		end
		return n;
	endfunction

	function automatic list_result_t apply_cmd(input cmd_item_t it);
		list_result_t r;
		ptr_t n, hit, prev, cur;
		logic [7:0] pos;
		int steps;
		r.status = STS_OK;
		r.position = 8'd0;
		r.node_index = '0;
		case (it.cmd)
			CMD_INS_HEAD, CMD_INS_TAIL: begin
				n = take_node();
				if (n >= NIL) begin
					r.status = STS_FULL;
				end else begin
					val_mem[n[IDX_W-1:0]] = it.value;
					if (it.cmd == CMD_INS_HEAD) begin
						next_mem[n[IDX_W-1:0]] = head_p;
						head_p = n;
					end else begin
						next_mem[n[IDX_W-1:0]] = NIL;
						if (head_p >= NIL) begin
							head_p = n;
						end else begin
							cur = head_p;
							steps = 0;
							while (next_mem[cur[IDX_W-1:0]] < NIL && steps < NODES) begin
								cur = next_mem[cur[IDX_W-1:0]];
								steps++;
							end
							next_mem[cur[IDX_W-1:0]] = n;
						end
					end
					r.node_index = n[IDX_W-1:0];
				end
			end
			CMD_INS_AFTER: begin
				hit = locate(it.key, prev, pos);
				if (hit >= NIL) begin
					r.status = STS_NOT_FOUND;
				end else begin
					n = take_node();
					if (n >= NIL) begin
						r.status = STS_FULL;
					end else begin
						val_mem[n[IDX_W-1:0]] = it.value;
						next_mem[n[IDX_W-1:0]] = next_mem[hit[IDX_W-1:0]];
						next_mem[hit[IDX_W-1:0]] = n;
						r.node_index = n[IDX_W-1:0];
					end
				end
			end
			CMD_DELETE: begin
				if (head_p >= NIL) begin
					r.status = STS_EMPTY;
				end else begin
					hit = locate(it.key, prev, pos);
					if (hit >= NIL) begin
						r.status = STS_NOT_FOUND;
					end else begin
						if (prev < NIL)
							next_mem[prev[IDX_W-1:0]] = next_mem[hit[IDX_W-1:0]];
						else
							head_p = next_mem[hit[IDX_W-1:0]];
						val_mem[hit[IDX_W-1:0]] = 32'd0;
						next_mem[hit[IDX_W-1:0]] = free_p;
						free_p = hit;
						if (node_cnt > 0)
							node_cnt--;
						r.node_index = hit[IDX_W-1:0];
					end
				end
			end
			CMD_SEARCH: begin
				hit = locate(it.key, prev, pos);
				if (hit >= NIL) begin
					r.status = STS_NOT_FOUND;
				end else begin
					r.position = pos;
					r.node_index = hit[IDX_W-1:0];
				end
			end
			default: begin
			end
		endcase
		r.live = node_cnt[7:0];
		return r;
	endfunction

	// stimulus side keeps the multiset of list values to aim keys at live nodes
	function automatic int live_slot(input logic [31:0] k);
		foreach (live_vals[i])
			if (live_vals[i] == k)
				return i;
		return -1;
	endfunction

	function automatic void add_item(input logic [2:0] c, input logic [31:0] k,
			input logic [31:0] v);
		cmd_item_t it;
		int slot;
		it.cmd = c;
		it.key = k;
		it.value = v;
		cmd_q.push_back(it);
		slot = live_slot(k);
		case (c)
			CMD_INS_HEAD, CMD_INS_TAIL:
				if (live_vals.size() < NODES)
					live_vals.push_back(v);
			CMD_INS_AFTER:
				if (slot >= 0 && live_vals.size() < NODES)
					live_vals.push_back(v);
			CMD_DELETE:
				if (slot >= 0)
					live_vals.delete(slot);
			default: begin
			end
		endcase
	endfunction

	function automatic logic [31:0] pick_value();
		if ($urandom_range(99) < 50)
			return 32'($urandom_range(15)) - 32'd8;
		return $urandom;
	endfunction

	function automatic logic [31:0] pick_key(input int hit_pct);
		if (live_vals.size() != 0 && $urandom_range(99) < hit_pct)
			return live_vals[$urandom_range(live_vals.size() - 1)];
		return pick_value();
	endfunction

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$display("%0t mismatch %s: expected %0d, actual %0d", $time, name, exp_v, act_v);
			n_errors++;
		end
	endtask

	always @(posedge clk) begin : driver
		if (arst_n) begin
			if (start && !busy) begin
				due_q.push_back(apply_cmd(cmd_q.pop_front()));
				n_accepted++;
			end
			if (!(start && busy)) begin
				if (cmd_q.size() != 0 &&
						((n_accepted >= 300 && n_accepted < 450) || $urandom_range(99) >= 25)) begin
					start <= 1'b1;
					command <= cmd_q[0].cmd;
					key <= cmd_q[0].key;
					new_value <= cmd_q[0].value;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : monitor
		list_result_t exp_r;
		if (arst_n && done) begin
			n_results++;
			if (due_q.size() == 0) begin
				$display("%0t unexpected result: status %0d node_index %0d", $time, status,
					node_index);
				n_errors++;
			end else begin
				exp_r = due_q.pop_front();
				check_field("status", exp_r.status, status);
				check_field("position", exp_r.position, position);
				check_field("node_index", exp_r.node_index, node_index);
				check_field("live_nodes", exp_r.live, live_nodes);
				case (exp_r.status)
					STS_FULL: n_full++;
					STS_NOT_FOUND: n_missing++;
					STS_EMPTY: n_empty++;
					default: begin
					end
				endcase
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((start && !busy) || done)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t timeout: %0d items pending, %0d results due", $time,
					cmd_q.size(), due_q.size());
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int made;
		int r;
		logic [2:0] c;
		head_p = NIL;
		free_p = '0;
		node_cnt = 0;
		for (int i = 0; i < NODES; i++) begin
			val_mem[i] = 32'd0;
			next_mem[i] = ptr_t'(i + 1);
		end

		add_item(CMD_DELETE, 32'd5, 32'd0);
		add_item(CMD_SEARCH, 32'd0, 32'd0);
		add_item(CMD_INS_AFTER, 32'd0, 32'd1);
		add_item(CMD_INS_TAIL, 32'h0, 32'h7fffffff);
		add_item(CMD_INS_HEAD, 32'h0, 32'h80000000);
		add_item(CMD_INS_TAIL, 32'hffffffff, 32'h0);
		add_item(CMD_INS_HEAD, 32'h7fffffff, 32'hffffffff);
		add_item(CMD_SEARCH, 32'h0, 32'hffffffff);
		add_item(CMD_SEARCH, 32'h80000000, 32'h0);
		add_item(CMD_SEARCH, 32'd12345, 32'h0);
		add_item(CMD_INS_AFTER, 32'h7fffffff, 32'h55555555);
		add_item(CMD_INS_AFTER, 32'h0, 32'haaaaaaaa);
		add_item(CMD_INS_AFTER, 32'd99, 32'd3);
		add_item(CMD_DELETE, 32'hffffffff, 32'h0);
		add_item(CMD_DELETE, 32'h7fffffff, 32'h0);
		add_item(CMD_DELETE, 32'd777, 32'h0);
		add_item(CMD_INS_HEAD, 32'h0, 32'h0);
		add_item(CMD_DELETE, 32'h0, 32'h0);
		add_item(CMD_SEARCH, 32'h0, 32'h0);
		add_item(CMD_SEARCH, 32'haaaaaaaa, 32'h0);
		for (int u = int'(CMD_SEARCH) + 1; u <= 7; u++)
			add_item(3'(u), 32'hffffffff, 32'hffffffff);

		// mixed, fill to full, mixed, drain to empty, mixed
		made = 0;
		while (made < RANDOM_ITEMS) begin
			r = $urandom_range(99);
			if (made >= 150 && made < 300 && live_vals.size() < NODES) begin
				c = 3'($urandom_range(2));
				add_item(c, pick_key(100), pick_value());
			end else if (made >= 450 && made < 600 && live_vals.size() != 0) begin
				add_item(CMD_DELETE, pick_key(100), pick_value());
			end else if (r < 2) begin
				add_item(3'($urandom_range(7, int'(CMD_SEARCH) + 1)), $urandom, $urandom);
				made--;
			end else begin
				if (r < 55)
					c = 3'($urandom_range(2));
				else if (r < 78)
					c = CMD_DELETE;
				else
					c = CMD_SEARCH;
				add_item(c, pick_key(70), pick_value());
			end
			made++;
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_q.size() != 0 || start || due_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("run covered %0d commands and %0d results over fill, drain and mixed phases",
			n_accepted, n_results);
		$display("pool full %0d, key not found %0d, delete on empty %0d", n_full, n_missing,
			n_empty);
		if (n_errors == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", n_errors);
			$display("status: fail");
		end
		$finish;
	end

endmodule
